// ===== design/zero_crossing_rate_detector_assert.svh =====
// Assertion macros shared by the zero crossing rate detector RTL
`ifndef ZERO_CROSSING_RATE_DETECTOR_ASSERT_SVH
`define ZERO_CROSSING_RATE_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define ZCRD_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ZCRD_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/zcrd_pkg.sv =====
// Shared constants, types and ring pointer helpers of the zero crossing rate detector
`default_nettype none

package zcrd_pkg;

    // Channel and storage sizing
    localparam int CHAN_W      = 4;
    localparam int CHANNELS    = 1 << CHAN_W;
    localparam int MAX_EVENTS  = 64;
    localparam int EV_PTR_W    = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int FILL_W      = $clog2(MAX_EVENTS + 1);
    localparam int EV_DEPTH    = CHANNELS << EV_PTR_W;
    localparam int EV_ADDR_W   = CHAN_W + EV_PTR_W;

    // Field widths
    localparam int SAMPLE_BITS = 24;
    localparam int CLK_W       = 32;
    localparam int HYST_W      = SAMPLE_BITS - 1;
    localparam int WIN_W       = CLK_W - 1;
    localparam int SCALE_W     = 24;
    localparam int COUNT_W     = 7;
    localparam int RATE_W      = 30;
    localparam int CROSS_W     = 2;

    // Register port
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_HYST   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SCALE  = 2'd2;

    localparam logic [HYST_W-1:0]  HYST_RESET   = '0;
    localparam logic [WIN_W-1:0]   WINDOW_RESET = 31'd256;
    localparam logic [SCALE_W-1:0] SCALE_RESET  = 24'd3932160;

    // Crossing codes
    localparam logic signed [CROSS_W-1:0] CROSS_NONE = 2'sb00;
    localparam logic signed [CROSS_W-1:0] CROSS_RISE = 2'sb01;
    localparam logic signed [CROSS_W-1:0] CROSS_FALL = 2'sb11;

    // Per-channel state word held in the channel memory
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] prev;
        logic                          pol;
        logic [CLK_W-1:0]              clk;
        logic [EV_PTR_W-1:0]           head;
        logic [FILL_W-1:0]             fill;
    } chan_state_t;

    localparam int CHAN_STATE_W = $bits(chan_state_t);

    typedef struct packed {
        logic [HYST_W-1:0]  hysteresis;
        logic [WIN_W-1:0]   window;
        logic [SCALE_W-1:0] scale;
    } cfg_t;

    // Outcome of one update step for the item in the execute stage
    typedef struct packed {
        chan_state_t                 next;
        logic signed [CROSS_W-1:0]   crossing;
        logic                        ovf;
        logic [COUNT_W-1:0]          count;
        logic [RATE_W-1:0]           rate;
        logic                        drain;
        logic [EV_PTR_W-1:0]         drain_head;
        logic [FILL_W-1:0]           drain_fill;
        logic                        ev_we;
        logic [EV_PTR_W-1:0]         ev_slot;
        logic [CLK_W-1:0]            ev_time;
    } step_out_t;

    // Ring pointer plus one, wrapping at MAX_EVENTS
    function automatic logic [EV_PTR_W-1:0] ptr_inc(input logic [EV_PTR_W-1:0] p);
        logic [EV_PTR_W:0] s;
        s = {1'b0, p} + (EV_PTR_W + 1)'(1);
        if (s >= (EV_PTR_W + 1)'(MAX_EVENTS)) begin
            s = '0;
        end
        return s[EV_PTR_W-1:0];
    endfunction

    // Ring pointer plus an offset below MAX_EVENTS
    function automatic logic [EV_PTR_W-1:0] ptr_add(input logic [EV_PTR_W-1:0] p,
                                                     input logic [FILL_W-1:0] f);
        logic [EV_PTR_W:0] s;
        s = {1'b0, p} + (EV_PTR_W + 1)'(f);
        if (s >= (EV_PTR_W + 1)'(MAX_EVENTS)) begin
            s = s - (EV_PTR_W + 1)'(MAX_EVENTS);
        end
        return s[EV_PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/zero_crossing_rate_detector.sv =====
// Top level: channel state memory, event time memory and the three-stage item pipeline
//
// Usage:
//   Input items (s_channel, s_sample, s_first_sample) enter on s_valid/s_ready;
//   one result item per input leaves on m_valid/m_ready in input order.
//   Registers (hysteresis, window_samples, rate_scale) sit at byte addresses 0, 4 and 8
//   of the APB-style port; the user must write them only while the block is idle; the block does not enforce it.
// Pipeline and throughput:
//   An accepted item passes the read stage, the execute stage and the output
//   register; one item per cycle is sustained while m_ready is high and no drain
//   walk runs, also for back-to-back items on the same channel, which are forwarded
//   around the channel and event memories. After a write to window_samples, the
//   first item of each channel holds the execute stage while it walks out each
//   further stale crossing (at most 63) through the event memory's single read port.
// Reset:
//   Synchronous, active low. Channel state reads as zero through per-channel
//   valid bits, so no clearing pass is needed and s_ready is high right away.
// Stalls:
//   With m_ready low the output register holds its item; two more items are
//   taken into the pipeline before s_ready drops.
`default_nettype none

module zero_crossing_rate_detector (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [zcrd_pkg::CHAN_W-1:0]         s_channel,
    input  logic signed [zcrd_pkg::SAMPLE_BITS-1:0] s_sample,
    input  logic                                s_first_sample,
    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [zcrd_pkg::CHAN_W-1:0]         m_out_channel,
    output logic signed [zcrd_pkg::CROSS_W-1:0] m_crossing,
    output logic [zcrd_pkg::COUNT_W-1:0]        m_event_count,
    output logic [zcrd_pkg::RATE_W-1:0]         m_rate,
    output logic                                m_overflow,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [zcrd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [zcrd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [zcrd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    import zcrd_pkg::*;

`include "zero_crossing_rate_detector_assert.svh"

    cfg_t                          cfg;
    logic                          window_wr;
    step_out_t                     step;

    // Read stage
    logic                          b_valid_reg;
    logic [CHAN_W-1:0]             b_chan_reg;
    logic signed [SAMPLE_BITS-1:0] b_sample_reg;
    logic                          b_first_reg;
    chan_state_t                   b_state_fwd;

    // Execute stage
    logic                          c_valid_reg;
    logic [CHAN_W-1:0]             c_chan_reg;
    logic signed [SAMPLE_BITS-1:0] c_sample_reg;
    logic                          c_first_reg;
    chan_state_t                   c_state_reg;

    // Last channel memory write, for read-during-write forwarding
    logic                          w_valid_reg;
    logic [CHAN_W-1:0]             w_chan_reg;
    chan_state_t                   w_state_reg;

    // Output register
    logic                          m_valid_reg;
    logic [CHAN_W-1:0]             m_out_channel_reg;
    logic signed [CROSS_W-1:0]     m_crossing_reg;
    logic [COUNT_W-1:0]            m_event_count_reg;
    logic [RATE_W-1:0]             m_rate_reg;
    logic                          m_overflow_reg;

    // Channel memory
    logic [CHANNELS-1:0]           st_valid_reg;
    logic                          st_rvalid_reg;
    logic [CHAN_W-1:0]             st_raddr;
    logic [CHAN_STATE_W-1:0]       st_rdata;
    chan_state_t                   st_ram_state;
    chan_state_t                   st_rd_state;

    // Event time memory
    logic [EV_ADDR_W-1:0]          ev_raddr;
    logic [EV_ADDR_W-1:0]          ev_waddr;
    logic                          ev_we;
    logic [CLK_W-1:0]              ev_rdata;
    logic                          ev_byp_hit_reg;
    logic [CLK_W-1:0]              ev_byp_data_reg;
    logic [CLK_W-1:0]              head_time;

    // Channels whose store may hold several stale entries after a window change
    logic [CHANNELS-1:0]           dirty_reg;

    // Pipeline control
    logic out_free;
    logic c_done;
    logic c_drain;
    logic c_free;
    logic b_adv;
    logic accept;

    zcrd_apb_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .window_wr (window_wr)
    );

    zcrd_step u_step (
        .state_in  (c_state_reg),
        .first_in  (c_first_reg),
        .sample_in (c_sample_reg),
        .head_time (head_time),
        .cfg       (cfg),
        .dirty     (dirty_reg[c_chan_reg]),
        .step_out  (step)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign c_drain  = c_valid_reg && step.drain;
    assign c_done   = c_valid_reg && !step.drain && out_free;
    assign c_free   = !c_valid_reg || c_done;
    assign b_adv    = b_valid_reg && c_free;
    assign s_ready  = !b_valid_reg || c_free;
    assign accept   = s_valid && s_ready;

    // Channel state memory: re-read the held address while the read stage waits
    assign st_raddr = accept ? s_channel : b_chan_reg;

    zcrd_ram #(
        .WIDTH (CHAN_STATE_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .clk   (aclk),
        .we    (c_done),
        .waddr (c_chan_reg),
        .wdata (step.next),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign st_ram_state = st_rdata;
    assign st_rd_state  = st_rvalid_reg ? st_ram_state : '0;

    // Forward the newest state of the channel into the read stage
    always_comb begin
        if (c_done && (c_chan_reg == b_chan_reg)) begin
            b_state_fwd = step.next;
        end else if (w_valid_reg && (w_chan_reg == b_chan_reg)) begin
            b_state_fwd = w_state_reg;
        end else begin
            b_state_fwd = st_rd_state;
        end
    end

    // Event memory read: next item's head, the drain walk, or a hold re-read
    always_comb begin
        if (b_adv) begin
            ev_raddr = {b_chan_reg, b_state_fwd.head};
        end else if (c_drain) begin
            ev_raddr = {c_chan_reg, step.drain_head};
        end else begin
            ev_raddr = {c_chan_reg, c_state_reg.head};
        end
    end

    assign ev_we    = c_done && step.ev_we;
    assign ev_waddr = {c_chan_reg, step.ev_slot};

    zcrd_ram #(
        .WIDTH (CLK_W),
        .DEPTH (EV_DEPTH)
    ) u_event_ram (
        .clk   (aclk),
        .we    (ev_we),
        .waddr (ev_waddr),
        .wdata (step.ev_time),
        .raddr (ev_raddr),
        .rdata (ev_rdata)
    );

    assign head_time = ev_byp_hit_reg ? ev_byp_data_reg : ev_rdata;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            w_valid_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            st_valid_reg   <= '0;
            st_rvalid_reg  <= 1'b0;
            ev_byp_hit_reg <= 1'b0;
            dirty_reg      <= '0;
        end else begin
            if (accept) begin
                b_valid_reg <= 1'b1;
            end else if (b_adv) begin
                b_valid_reg <= 1'b0;
            end

            if (b_adv) begin
                c_valid_reg <= 1'b1;
            end else if (c_done) begin
                c_valid_reg <= 1'b0;
            end

            if (c_done) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            w_valid_reg    <= c_done;
            st_rvalid_reg  <= st_valid_reg[st_raddr];
            ev_byp_hit_reg <= ev_we && (ev_waddr == ev_raddr);

            if (c_done) begin
                st_valid_reg[c_chan_reg] <= 1'b1;
            end

            if (window_wr) begin
                dirty_reg <= '1;
            end else if (c_done) begin
                dirty_reg[c_chan_reg] <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            b_chan_reg   <= s_channel;
            b_sample_reg <= s_sample;
            b_first_reg  <= s_first_sample;
        end

        if (b_adv) begin
            c_chan_reg   <= b_chan_reg;
            c_sample_reg <= b_sample_reg;
            c_first_reg  <= b_first_reg;
            c_state_reg  <= b_state_fwd;
        end else if (c_drain) begin
            c_state_reg.head <= step.drain_head;
            c_state_reg.fill <= step.drain_fill;
        end

        w_chan_reg      <= c_chan_reg;
        w_state_reg     <= step.next;
        ev_byp_data_reg <= step.ev_time;

        if (c_done) begin
            m_out_channel_reg <= c_chan_reg;
            m_crossing_reg    <= step.crossing;
            m_event_count_reg <= step.count;
            m_rate_reg        <= step.rate;
            m_overflow_reg    <= step.ovf;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_channel = m_out_channel_reg;
    assign m_crossing    = m_crossing_reg;
    assign m_event_count = m_event_count_reg;
    assign m_rate        = m_rate_reg;
    assign m_overflow    = m_overflow_reg;

    // A drain walk holds off new items once the read stage is full
    `ZCRD_ASSERT_IMP(a_drain_holds_input, aclk, aresetn, c_drain && b_valid_reg, !s_ready, "input taken during drain")

    // Each drain step removes one stale entry
    `ZCRD_ASSERT_NXT(a_drain_shrinks, aclk, aresetn, c_drain, c_valid_reg && (c_state_reg.fill == $past(step.drain_fill)), "drain step lost its item or fill")

    // Store fill never exceeds its capacity
    `ZCRD_ASSERT_IMP(a_fill_bound, aclk, aresetn, c_valid_reg, c_state_reg.fill <= FILL_W'(MAX_EVENTS), "event fill beyond capacity")

    // Overflow only on a rising crossing into a full store
    `ZCRD_ASSERT_IMP(a_ovf_full, aclk, aresetn, m_valid_reg && m_overflow_reg, (m_crossing_reg == CROSS_RISE) && (m_event_count_reg == COUNT_W'(MAX_EVENTS)), "overflow without full store")

endmodule

`default_nettype wire

// ===== design/zcrd_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module zcrd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/zcrd_apb_regs.sv =====
// Configuration register file behind the APB-style port
`default_nettype none

module zcrd_apb_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [zcrd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [zcrd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [zcrd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output zcrd_pkg::cfg_t                  cfg,
    output logic                            window_wr
);

    import zcrd_pkg::*;

    logic [HYST_W-1:0]    hysteresis_reg;
    logic [WIN_W-1:0]     window_reg;
    logic [SCALE_W-1:0]   scale_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hysteresis_reg <= HYST_RESET;
            window_reg     <= WINDOW_RESET;
            scale_reg      <= SCALE_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_HYST:   hysteresis_reg <= pwdata[HYST_W-1:0];
                REG_WINDOW: window_reg     <= pwdata[WIN_W-1:0];
                REG_SCALE:  scale_reg      <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            REG_HYST:   prdata = APB_DATA_W'(hysteresis_reg);
            REG_WINDOW: prdata = APB_DATA_W'(window_reg);
            REG_SCALE:  prdata = APB_DATA_W'(scale_reg);
            default:    prdata = '0;
        endcase
    end

    // A new window may leave several stored crossings stale on any channel
    assign window_wr = wr_en && (reg_idx == REG_WINDOW);

    assign cfg.hysteresis = hysteresis_reg;
    assign cfg.window     = window_reg;
    assign cfg.scale      = scale_reg;

endmodule

`default_nettype wire

// ===== design/zcrd_step.sv =====
// Per-item update: crossing test, window expiry, event store append and rate
`default_nettype none

module zcrd_step (
    input  zcrd_pkg::chan_state_t                state_in,
    input  logic                                 first_in,
    input  logic signed [zcrd_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic [zcrd_pkg::CLK_W-1:0]           head_time,
    input  zcrd_pkg::cfg_t                       cfg,
    input  logic                                 dirty,
    output zcrd_pkg::step_out_t                  step_out
);

    import zcrd_pkg::*;

    chan_state_t                   st_eff;
    logic signed [SAMPLE_BITS:0]   prev_x;
    logic signed [SAMPLE_BITS:0]   samp_x;
    logic signed [SAMPLE_BITS:0]   hyst_p;
    logic signed [SAMPLE_BITS:0]   hyst_n;
    logic                          fall;
    logic                          rise;
    logic [CLK_W-1:0]              now1;
    logic [CLK_W-1:0]              age;
    logic                          exp1;
    logic                          small_win;
    logic                          store_ok;
    logic [EV_PTR_W-1:0]           head1;
    logic [EV_PTR_W-1:0]           head2;
    logic [FILL_W-1:0]             fill1;
    logic [FILL_W-1:0]             fill2;
    logic [FILL_W+SCALE_W-1:0]     product;

    // Restart clears the channel before the sample is used
    always_comb begin
        st_eff = state_in;
        if (first_in) begin
            st_eff.prev = '0;
            st_eff.pol  = ~sample_in[SAMPLE_BITS-1];
            st_eff.clk  = '0;
            st_eff.head = '0;
            st_eff.fill = '0;
        end
    end

    // Hysteresis compare on one extra bit so -hysteresis always fits
    assign prev_x = $signed({st_eff.prev[SAMPLE_BITS-1], st_eff.prev});
    assign samp_x = $signed({sample_in[SAMPLE_BITS-1], sample_in});
    assign hyst_p = $signed({2'b00, cfg.hysteresis});
    assign hyst_n = -hyst_p;

    assign fall = st_eff.pol && (prev_x > hyst_n) && (samp_x < hyst_n);
    assign rise = !st_eff.pol && (prev_x < hyst_p) && (samp_x > hyst_p);

    // Head expiry; ages are modulo 2^32
    assign now1 = st_eff.clk + CLK_W'(1);
    assign age  = now1 - head_time;
    assign exp1 = (st_eff.fill != '0) && (age >= {1'b0, cfg.window});

    assign head1 = exp1 ? ptr_inc(st_eff.head) : st_eff.head;
    assign fill1 = st_eff.fill - FILL_W'(exp1);

    // A window of zero or one expires a new crossing on the sample that made it
    assign small_win = (cfg.window <= WIN_W'(1));
    assign store_ok  = rise && (fill1 < FILL_W'(MAX_EVENTS));

    always_comb begin
        head2 = head1;
        fill2 = fill1;
        if (store_ok && small_win) begin
            head2 = ptr_inc(head1);
        end else if (store_ok) begin
            fill2 = fill1 + FILL_W'(1);
        end
    end

    assign product = (FILL_W + SCALE_W)'(fill2) * (FILL_W + SCALE_W)'(cfg.scale);

    always_comb begin
        step_out.next.prev  = sample_in;
        step_out.next.pol   = fall ? 1'b0 : (rise ? 1'b1 : st_eff.pol);
        step_out.next.clk   = now1;
        step_out.next.head  = head2;
        step_out.next.fill  = fill2;
        step_out.crossing   = fall ? CROSS_FALL : (rise ? CROSS_RISE : CROSS_NONE);
        step_out.ovf        = rise && !store_ok;
        step_out.count      = COUNT_W'(fill2);
        step_out.rate       = product[RATE_W-1:0];
        // after a window change more than one entry may be stale: walk them
        step_out.drain      = dirty && !first_in && exp1 && (fill1 != '0);
        step_out.drain_head = head1;
        step_out.drain_fill = fill1;
        step_out.ev_we      = store_ok;
        step_out.ev_slot    = ptr_add(head1, fill1);
        step_out.ev_time    = st_eff.clk;
    end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench of the zero crossing rate detector
`timescale 1ns / 1ps

module tb;
    import zcrd_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int SMP_MAX      = 8388607;

    // One result item as the block should produce it
    typedef struct packed {
        logic [CHAN_W-1:0]  chan;
        logic [CROSS_W-1:0] crossing;
        logic [COUNT_W-1:0] count;
        logic [RATE_W-1:0]  rate;
        logic               ovf;
    } zc_result_t;

    // One row of the directed part; want is used only where typed is set
    typedef struct packed {
        logic [CHAN_W-1:0]      chan;
        logic [SAMPLE_BITS-1:0] smp;
        logic                   restart;
        logic                   typed;
        zc_result_t             want;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [CHAN_W-1:0]             s_channel = '0;
    logic signed [SAMPLE_BITS-1:0] s_sample = '0;
    logic                          s_first_sample = 1'b0;

    logic                          m_valid;
    logic                          m_ready = 1'b1;
    logic [CHAN_W-1:0]             m_out_channel;
    logic signed [CROSS_W-1:0]     m_crossing;
    logic [COUNT_W-1:0]            m_event_count;
    logic [RATE_W-1:0]             m_rate;
    logic                          m_overflow;

    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]         paddr = '0;
    logic [APB_DATA_W-1:0]         pwdata = '0;
    logic [APB_DATA_W-1:0]         prdata;
    logic                          pready;

    zero_crossing_rate_detector uut (.*);

    always #10 aclk = ~aclk;

    // Shadow of the registers
    logic [HYST_W-1:0]  hyst_q  = HYST_RESET;
    logic [WIN_W-1:0]   win_q   = WINDOW_RESET;
    logic [SCALE_W-1:0] scale_q = SCALE_RESET;

    // Shadow of the per-channel state
    logic signed [SAMPLE_BITS-1:0] chan_prev  [CHANNELS];
    logic                          chan_pos   [CHANNELS];
    logic [CLK_W-1:0]              chan_clock [CHANNELS];
    logic [CLK_W-1:0]              rise_time  [CHANNELS][MAX_EVENTS];
    logic [EV_PTR_W-1:0]           rise_head  [CHANNELS];
    logic [FILL_W-1:0]             rise_fill  [CHANNELS];

    zc_result_t pending_results [$];

    int send_idle = 0;
    int recv_stall = 0;
    int mismatches = 0;
    int n_items = 0;
    int n_checked = 0;
    int n_rise = 0;
    int n_fall = 0;
    int n_dropped = 0;

    initial begin
        for (int c = 0; c < CHANNELS; c++) begin
            chan_prev[c]  = '0;
            chan_pos[c]   = 1'b0;
            chan_clock[c] = '0;
            rise_head[c]  = '0;
            rise_fill[c]  = '0;
        end
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    // Retire stored rising crossings that have aged out of the window
    function automatic void drop_stale(input int ch, input logic [CLK_W-1:0] now1);
        logic [CLK_W-1:0] age;
        while (rise_fill[ch] > 0) begin
            age = now1 - rise_time[ch][rise_head[ch]];
            if (age < {1'b0, win_q})
                break;
            rise_head[ch] = rise_head[ch] + 1'b1;
            rise_fill[ch] = rise_fill[ch] - 1'b1;
        end
    endfunction

    // Advance the channel shadow by one sample and return the result it yields
    function automatic zc_result_t predict_crossing(input logic [CHAN_W-1:0] chan,
                                                    input logic signed [SAMPLE_BITS-1:0] smp,
                                                    input logic restart);
        zc_result_t res;
        int ch, h, p, s;
        logic [CLK_W-1:0] now1;
        logic [37:0] prod;
        ch = int'(chan);
        res = '0;
        res.chan = chan;
        res.crossing = CROSS_NONE;
        if (restart) begin
            chan_prev[ch]  = '0;
            chan_pos[ch]   = (smp >= 0);
            chan_clock[ch] = '0;
            rise_head[ch]  = '0;
            rise_fill[ch]  = '0;
        end
        h = int'(hyst_q);
        p = int'(chan_prev[ch]);
        s = int'(smp);
        if (chan_pos[ch] && p > -h && s < -h) begin
            res.crossing = CROSS_FALL;
            chan_pos[ch] = 1'b0;
        end else if (!chan_pos[ch] && p < h && s > h) begin
            res.crossing = CROSS_RISE;
            chan_pos[ch] = 1'b1;
        end
        chan_prev[ch] = smp;
        now1 = chan_clock[ch] + 1;
        drop_stale(ch, now1);
        if (res.crossing == CROSS_RISE) begin
            if (rise_fill[ch] >= FILL_W'(MAX_EVENTS)) begin
                res.ovf = 1'b1;
            end else begin
                rise_time[ch][EV_PTR_W'(rise_head[ch] + rise_fill[ch])] = chan_clock[ch];
                rise_fill[ch] = rise_fill[ch] + 1'b1;
            end
        end
        drop_stale(ch, now1);
        chan_clock[ch] = now1;
        prod = rise_fill[ch] * scale_q;
        res.count = COUNT_W'(rise_fill[ch]);
        res.rate = prod[RATE_W-1:0];
        return res;
    endfunction

    // Sample beyond the band on the given side, often close to the threshold
    function automatic logic [SAMPLE_BITS-1:0] past_band(input bit pos, input int hy);
        int lo, hi, m;
        lo = hy + 1;
        if (pos) begin
            if (hy >= SMP_MAX)
                return SAMPLE_BITS'(SMP_MAX);
            hi = ($urandom_range(0, 1) != 0) ? SMP_MAX : ((lo + 15 > SMP_MAX) ? SMP_MAX : lo + 15);
            m = int'($urandom_range(hi, lo));
            return SAMPLE_BITS'(m);
        end
        hi = ($urandom_range(0, 1) != 0) ? SMP_MAX + 1
                                          : ((lo + 15 > SMP_MAX + 1) ? SMP_MAX + 1 : lo + 15);
        m = int'($urandom_range(hi, lo));
        return SAMPLE_BITS'(-m);
    endfunction

    // Present one item, hold it until taken, then queue what it should produce
    task automatic send_item(input logic [CHAN_W-1:0] chan,
                             input logic [SAMPLE_BITS-1:0] smp,
                             input logic restart,
                             input logic typed,
                             input zc_result_t want);
        zc_result_t res;
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_channel      <= chan;
        s_sample       <= smp;
        s_first_sample <= restart;
        do @(posedge aclk); while (!s_ready);
        res = predict_crossing(chan, smp, restart);
        pending_results.push_back(typed ? want : res);
        n_items++;
    endtask

    // Write one register, read it back, and update the shadow
    task automatic program_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        logic [APB_DATA_W-1:0] got;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        // back-to-back read of the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        got = prdata;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_HYST:   hyst_q  = val[HYST_W-1:0];
            REG_WINDOW: win_q   = val[WIN_W-1:0];
            REG_SCALE:  scale_q = val[SCALE_W-1:0];
            default: ;
        endcase
        if (got !== val)
            note_mismatch($sformatf("register %0d readback: expected 0x%0h, got 0x%0h",
                                    idx, val, got));
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Result side backpressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : check_results
        zc_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result: ch %0d cross %0d count %0d",
                                        m_out_channel, m_crossing, m_event_count));
            end else begin
                exp_r = pending_results.pop_front();
                n_checked++;
                if (exp_r.crossing == CROSS_RISE) n_rise++;
                if (exp_r.crossing == CROSS_FALL) n_fall++;
                if (exp_r.ovf) n_dropped++;
                if (m_out_channel !== exp_r.chan || m_crossing !== exp_r.crossing ||
                    m_event_count !== exp_r.count || m_rate !== exp_r.rate ||
                    m_overflow !== exp_r.ovf)
                    note_mismatch($sformatf(
                        "result %0d: expected ch %0d cross %0d count %0d rate %0d ovf %0d, got ch %0d cross %0d count %0d rate %0d ovf %0d",
                        n_checked, exp_r.chan, $signed(exp_r.crossing), exp_r.count,
                        exp_r.rate, exp_r.ovf, m_out_channel, m_crossing, m_event_count,
                        m_rate, m_overflow));
            end
        end
    end

    // Directed items under the reset settings (hysteresis 0, window 256)
    stim_row_t plan [22] = '{
        // polarity starts negative; a previous sample of zero is not below zero
        '{4'd0,  24'd100,       1'b0, 1'b1, '{4'd0,  CROSS_NONE, 7'd0, 30'd0,       1'b0}},
        '{4'd0,  -24'd5,        1'b0, 1'b1, '{4'd0,  CROSS_NONE, 7'd0, 30'd0,       1'b0}},
        '{4'd0,  24'd100,       1'b0, 1'b1, '{4'd0,  CROSS_RISE, 7'd1, 30'd3932160, 1'b0}},
        '{4'd0,  -24'd100,      1'b0, 1'b1, '{4'd0,  CROSS_FALL, 7'd1, 30'd3932160, 1'b0}},
        '{4'd0,  24'h7FFFFF,    1'b0, 1'b1, '{4'd0,  CROSS_RISE, 7'd2, 30'd7864320, 1'b0}},
        '{4'd0,  24'h800000,    1'b0, 1'b1, '{4'd0,  CROSS_FALL, 7'd2, 30'd7864320, 1'b0}},
        '{4'd0,  24'd0,         1'b0, 1'b1, '{4'd0,  CROSS_NONE, 7'd2, 30'd7864320, 1'b0}},
        // restart on zero: polarity positive, store emptied
        '{4'd0,  24'd0,         1'b1, 1'b1, '{4'd0,  CROSS_NONE, 7'd0, 30'd0,       1'b0}},
        '{4'd0,  -24'd1,        1'b0, 1'b1, '{4'd0,  CROSS_NONE, 7'd0, 30'd0,       1'b0}},
        '{4'd0,  24'd1,         1'b0, 1'b1, '{4'd0,  CROSS_NONE, 7'd0, 30'd0,       1'b0}},
        '{4'd0,  -24'd1,        1'b0, 1'b1, '{4'd0,  CROSS_FALL, 7'd0, 30'd0,       1'b0}},
        // restart on the most negative sample
        '{4'd15, 24'h800000,    1'b1, 1'b1, '{4'd15, CROSS_NONE, 7'd0, 30'd0,       1'b0}},
        '{4'd15, 24'h7FFFFF,    1'b0, 1'b1, '{4'd15, CROSS_RISE, 7'd1, 30'd3932160, 1'b0}},
        '{4'd15, 24'h7FFFFF,    1'b0, 1'b1, '{4'd15, CROSS_NONE, 7'd1, 30'd3932160, 1'b0}},
        '{4'd15, 24'h800000,    1'b0, 1'b1, '{4'd15, CROSS_FALL, 7'd1, 30'd3932160, 1'b0}},
        '{4'd5,  24'd1,         1'b0, 1'b1, '{4'd5,  CROSS_NONE, 7'd0, 30'd0,       1'b0}},
        '{4'd10, -24'd1,        1'b0, 1'b1, '{4'd10, CROSS_NONE, 7'd0, 30'd0,       1'b0}},
        '{4'd10, 24'd1,         1'b0, 1'b1, '{4'd10, CROSS_RISE, 7'd1, 30'd3932160, 1'b0}},
        // alternating bit patterns, checked by prediction
        '{4'd3,  24'h555555,    1'b0, 1'b0, '0},
        '{4'd12, 24'hAAAAAA,    1'b0, 1'b0, '0},
        '{4'd12, 24'h555555,    1'b0, 1'b0, '0},
        '{4'd3,  24'hAAAAAA,    1'b1, 1'b0, '0}
    };

    // Run limit
    initial begin
        #(LIMIT_CYCLES * 20);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Main sequence
    initial begin : stimulus
        bit want_pos [CHANNELS];
        int n, span, base, toggle_pct, noise_pct, restart_pct, mode;
        logic [31:0] h_val, w_val, sc_val;
        logic [CHAN_W-1:0] ch;
        logic [SAMPLE_BITS-1:0] smp;
        logic rst;

        for (int c = 0; c < CHANNELS; c++)
            want_pos[c] = 1'b0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i])
            send_item(plan[i].chan, plan[i].smp, plan[i].restart, plan[i].typed, plan[i].want);
        s_valid <= 1'b0;
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            mode = p % 4;
            toggle_pct = 70;
            noise_pct = 10;
            restart_pct = 3;
            h_val = 0;
            w_val = 256;
            sc_val = 3932160;
            case (p)
                0: begin n = 200; span = 16; end
                // widest band: rising crossings impossible
                1: begin
                    n = 150; span = 4;
                    h_val = SMP_MAX; w_val = 32'h7FFFFFFF; sc_val = 32'hFFFFFF;
                end
                // one channel toggling with an endless window fills the store
                2: begin
                    n = 300; span = 1; toggle_pct = 100; noise_pct = 0; restart_pct = 0;
                    w_val = 32'h7FFFFFFF; sc_val = 32'hFFFFFF;
                end
                // window of one: crossings expire on the sample that made them
                3: begin
                    n = 150; span = 16;
                    h_val = $urandom_range(0, 1000); w_val = 1; sc_val = $urandom_range(0, 32'hFFFFFF);
                end
                // window of zero, zero scale
                4: begin
                    n = 150; span = 16;
                    h_val = $urandom_range(0, SMP_MAX); w_val = 0; sc_val = 0;
                end
                5: begin
                    n = 200; span = 3;
                    h_val = $urandom_range(0, 1 << 20); w_val = $urandom_range(2, 40);
                    sc_val = $urandom_range(0, 32'hFFFFFF);
                end
                6: begin
                    n = 200; span = 8;
                    h_val = $urandom_range(0, SMP_MAX); w_val = $urandom_range(100, 1000);
                    sc_val = $urandom_range(0, 32'hFFFFFF);
                end
                default: begin
                    n = 150; span = 16; noise_pct = 30;
                end
            endcase

            if (p != 0) begin
                program_reg(REG_HYST, h_val);
                program_reg(REG_WINDOW, w_val);
                program_reg(REG_SCALE, sc_val);
            end

            send_idle  = (mode == 1) ? 79 : ((mode == 3) ? 17 : 0);
            recv_stall = (mode == 2) ? 79 : ((mode == 3) ? 17 : 0);
            base = $urandom_range(0, CHANNELS - 1);

            for (int i = 0; i < n; i++) begin
                ch = CHAN_W'(base + $urandom_range(0, span - 1));
                rst = ($urandom_range(0, 99) < restart_pct);
                if ($urandom_range(0, 99) < noise_pct) begin
                    // noise: full-range value or a value inside the band
                    if ($urandom_range(0, 1) != 0)
                        smp = SAMPLE_BITS'($urandom());
                    else
                        smp = SAMPLE_BITS'(int'($urandom_range(0, 2 * int'(hyst_q))) -
                                           int'(hyst_q));
                end else begin
                    if ($urandom_range(0, 99) < toggle_pct)
                        want_pos[ch] = !want_pos[ch];
                    smp = past_band(want_pos[ch], int'(hyst_q));
                end
                send_item(ch, smp, rst, 1'b0, '0);
            end
            s_valid <= 1'b0;
            wait_drained();
        end

        send_idle = 0;
        recv_stall = 0;
        $display("%0d items over 8 register settings, %0d results compared", n_items, n_checked);
        $display("crossings seen: %0d rising, %0d falling, %0d dropped on a full store",
                 n_rise, n_fall, n_dropped);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
